// ===== src/salct_pkg.sv =====
// ----------------------------------------------------------------------------
// salct_pkg: shared types and constants of the cache tracker
// Holds the queued transaction record, the back-end state encoding,
// memory control flags and configuration register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package salct_pkg;

    // Byte lanes of the backing store; one bank per lane.
    localparam int LANES  = 8;
    localparam int LANE_W = 3;

    // Depth of the queue between front and back end.
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;
    localparam int QCNT_W  = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED   = 2'd2;

    // Access kinds.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_STORE = 1'b1;

    // One classified transaction waiting for the back end.
    typedef struct packed {
        logic        is_store;
        logic [15:0] address;
        logic [3:0]  size;
        logic [63:0] store_data;
        logic [15:0] blk;
        logic [15:0] set_sel;
    } item_t;

    // Control flags from the back end to the backing store.
    typedef struct packed {
        logic acc_en;
        logic acc_we;
        logic clr_en;
    } mem_ctl_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_READ,
        S_UPDATE
    } back_state_t;

endpackage

// ===== src/salct_front.sv =====
// ----------------------------------------------------------------------------
// salct_front: accepts and classifies transactions
// Works out the block number, the set selection and the clamped size of
// each access and holds it in a short queue for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module salct_front #(
    parameter int MAX_ACCESS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 kind,
    input  logic [15:0]          address,
    input  logic [3:0]           access_size,
    input  logic [63:0]          store_data,
    input  logic [2:0]           offset_bits,
    input  logic [3:0]           index_bits,
    input  logic                 clearing,
    input  logic                 pop,
    output logic                 busy,
    output logic                 q_valid,
    output salct_pkg::item_t     q_entry
);

    salct_pkg::item_t                   entry_reg [salct_pkg::QDEPTH];
    logic [salct_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [salct_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [salct_pkg::QCNT_W-1:0]       count_reg, count_next;
    salct_pkg::item_t                   item_in;
    logic [15:0]                        blk;
    logic [15:0]                        set_mask;
    logic                               push;
    logic                               full;

    // Classify the incoming transaction.
    always_comb
    begin
        blk                = address >> offset_bits;
        set_mask           = 16'((17'd1 << index_bits) - 17'd1);
        item_in.is_store   = (kind == salct_pkg::KIND_STORE);
        item_in.address    = address;
        item_in.size       = (access_size > 4'(MAX_ACCESS)) ? 4'(MAX_ACCESS) : access_size;
        item_in.store_data = store_data;
        item_in.blk        = blk;
        item_in.set_sel    = blk & set_mask;
    end

    assign full    = (count_reg == salct_pkg::QCNT_W'(salct_pkg::QDEPTH));
    assign busy    = full || clearing;
    assign push    = start && !busy;
    assign q_valid = (count_reg != '0);
    assign q_entry = entry_reg[rd_ptr_reg];

    // Queue pointers and fill level.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= salct_pkg::QCNT_W'(salct_pkg::QDEPTH))
        else $error("queue fill level beyond its depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("transaction taken from an empty queue");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue did not grow on a lone push");

endmodule

// ===== src/salct_mem.sv =====
// ----------------------------------------------------------------------------
// salct_mem: byte-wide backing store
// Eight banks, one per byte lane, so that any run of up to eight bytes
// reads or writes as a single access; read data is registered and realigned.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module salct_mem #(
    parameter int MEM_BYTES = 65536
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  salct_pkg::mem_ctl_t       ctl,
    input  logic [$clog2(MEM_BYTES)-1:0]   acc_addr,
    input  logic [3:0]                acc_size,
    input  logic [63:0]               acc_data,
    input  logic [$clog2(MEM_BYTES)-4:0]   clr_word,
    output logic [63:0]               load_data
);

    localparam int AW    = $clog2(MEM_BYTES);
    localparam int WW    = AW - 3;
    localparam int WORDS = MEM_BYTES / salct_pkg::LANES;

    logic [WW-1:0]                    bank_word [salct_pkg::LANES];
    logic                             bank_we   [salct_pkg::LANES];
    logic [7:0]                       bank_wd   [salct_pkg::LANES];
    logic [7:0]                       rd_reg    [salct_pkg::LANES];
    logic [salct_pkg::LANE_W-1:0]     start_lo_reg;
    logic [3:0]                       size_reg;

    // Map each bank to the byte of the run that falls in it.
    always_comb
    begin
        logic [salct_pkg::LANE_W-1:0] d;
        for (int b = 0; b < salct_pkg::LANES; b++)
        begin
            d = salct_pkg::LANE_W'(b) - acc_addr[salct_pkg::LANE_W-1:0];
            if (ctl.clr_en)
            begin
                bank_word[b] = clr_word;
                bank_we[b]   = 1'b1;
                bank_wd[b]   = '0;
            end
            else
            begin
                bank_word[b] = WW'((acc_addr + AW'(d)) >> salct_pkg::LANE_W);
                bank_we[b]   = ctl.acc_en && ctl.acc_we && ({1'b0, d} < acc_size);
                bank_wd[b]   = acc_data[8*d +: 8];
            end
        end
    end

    // The banks themselves.
    for (genvar b = 0; b < salct_pkg::LANES; b++)
    begin : g_bank
        logic [7:0] mem [WORDS];

        always_ff @(posedge clk)
        begin
            if (bank_we[b])
            begin
                mem[bank_word[b]] <= bank_wd[b];
            end
            rd_reg[b] <= mem[bank_word[b]];
        end
    end

    // Keep the alignment of the read for the realignment next cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_lo_reg <= '0;
            size_reg     <= '0;
        end
        else if (ctl.acc_en)
        begin
            start_lo_reg <= acc_addr[salct_pkg::LANE_W-1:0];
            size_reg     <= acc_size;
        end
    end

    // Rotate the bank outputs back into access order; unused lanes read zero.
    always_comb
    begin
        logic [salct_pkg::LANE_W-1:0] lane;
        for (int i = 0; i < salct_pkg::LANES; i++)
        begin
            lane = start_lo_reg + salct_pkg::LANE_W'(i);
            load_data[8*i +: 8] = (4'(i) < size_reg) ? rd_reg[lane] : 8'd0;
        end
    end

endmodule

// ===== src/salct_back.sv =====
// ----------------------------------------------------------------------------
// salct_back: tag lookup and LRU update
// Takes transactions from the queue, reads the set's tag and rank row,
// works out hit, allocation or replacement and writes the row back.
// Also runs the clearing pass over the set fill counts and backing store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module salct_back #(
    parameter int MAX_SETS  = 256,
    parameter int MAX_WAYS  = 8,
    parameter int MEM_BYTES = 65536
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [3:0]                ways_used,
    input  logic                      q_valid,
    input  salct_pkg::item_t          q_entry,
    output logic                      pop,
    output logic                      clearing,
    output salct_pkg::mem_ctl_t       mem_ctl,
    output logic [$clog2(MEM_BYTES)-1:0]   acc_addr,
    output logic [3:0]                acc_size,
    output logic [63:0]               acc_data,
    output logic [$clog2(MEM_BYTES)-4:0]   clr_word,
    input  logic [63:0]               mem_load_data,
    output logic                      done,
    output logic                      hit,
    output logic [63:0]               load_data
);

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int FILL_W = $clog2(MAX_WAYS + 1);
    localparam int TAG_W  = 16;
    localparam int AW     = $clog2(MEM_BYTES);
    localparam int WW     = AW - 3;
    localparam int WORDS  = MEM_BYTES / salct_pkg::LANES;
    localparam int CLR_N  = (WORDS > MAX_SETS) ? WORDS : MAX_SETS;
    localparam int CLR_W  = $clog2(CLR_N);

    // Set rows: tags, ranks and fill count.
    logic [MAX_WAYS-1:0][TAG_W-1:0]   tag_mem  [MAX_SETS];
    logic [MAX_WAYS-1:0][WAY_W-1:0]   rank_mem [MAX_SETS];
    logic [FILL_W-1:0]                fill_mem [MAX_SETS];
    logic [MAX_WAYS-1:0][TAG_W-1:0]   tag_rd_reg;
    logic [MAX_WAYS-1:0][WAY_W-1:0]   rank_rd_reg;
    logic [FILL_W-1:0]                fill_rd_reg;

    salct_pkg::back_state_t           state_reg, state_next;
    logic [CLR_W-1:0]                 clr_cnt_reg, clr_cnt_next;
    salct_pkg::item_t                 cur_reg;
    logic                             done_reg, done_next;
    logic                             hit_reg;
    logic [63:0]                      load_data_reg;

    logic [SET_W-1:0]                 q_set, cur_set;
    logic                             row_re, row_we, fill_we;
    logic [SET_W-1:0]                 fill_waddr;
    logic [FILL_W-1:0]                fill_wdata;

    logic [MAX_WAYS-1:0]              way_valid, way_match;
    logic                             hit_c, alloc_c, replace_c;
    logic [WAY_W-1:0]                 hitway, victim, target;
    logic [WAY_W-1:0]                 touch_rank;
    logic [4:0]                       ways_c;
    logic [MAX_WAYS-1:0][TAG_W-1:0]   tag_new;
    logic [MAX_WAYS-1:0][WAY_W-1:0]   rank_new;
    logic [FILL_W-1:0]                fill_new;

    assign q_set   = SET_W'(q_entry.set_sel & 16'(MAX_SETS - 1));
    assign cur_set = SET_W'(cur_reg.set_sel & 16'(MAX_SETS - 1));

    // Sequencer: clearing pass, then read and update of one row per transaction.
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        pop          = 1'b0;
        row_re       = 1'b0;
        row_we       = 1'b0;
        done_next    = 1'b0;
        mem_ctl      = '0;
        case (state_reg)
            salct_pkg::S_CLEAR:
            begin
                mem_ctl.clr_en = (clr_cnt_reg < CLR_W'(WORDS - 1)) ||
                                 (clr_cnt_reg == CLR_W'(WORDS - 1));
                clr_cnt_next   = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_W'(CLR_N - 1))
                begin
                    state_next = salct_pkg::S_READ;
                end
            end
            salct_pkg::S_READ:
            begin
                if (q_valid)
                begin
                    pop            = 1'b1;
                    row_re         = 1'b1;
                    mem_ctl.acc_en = 1'b1;
                    mem_ctl.acc_we = q_entry.is_store;
                    state_next     = salct_pkg::S_UPDATE;
                end
            end
            salct_pkg::S_UPDATE:
            begin
                row_we     = 1'b1;
                done_next  = 1'b1;
                state_next = salct_pkg::S_READ;
            end
            default:
            begin
                state_next = salct_pkg::S_READ;
            end
        endcase
    end

    assign clearing = (state_reg == salct_pkg::S_CLEAR);
    assign acc_addr = AW'(q_entry.address);
    assign acc_size = q_entry.size;
    assign acc_data = q_entry.store_data;
    assign clr_word = WW'(clr_cnt_reg);

    // Lookup and replacement decision on the row read last cycle.
    always_comb
    begin
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            way_valid[i] = (FILL_W'(i) < fill_rd_reg);
            way_match[i] = way_valid[i] && (tag_rd_reg[i] == cur_reg.blk);
        end

        hitway = '0;
        victim = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--)
        begin
            if (way_match[i])
            begin
                hitway = WAY_W'(i);
            end
            // Filled ranks form a permutation, so the oldest holds fill minus one.
            if (way_valid[i] && (rank_rd_reg[i] == WAY_W'(fill_rd_reg - 1'b1)))
            begin
                victim = WAY_W'(i);
            end
        end

        if (ways_used == 4'd0)
        begin
            ways_c = 5'd1;
        end
        else if ({1'b0, ways_used} > 5'(MAX_WAYS))
        begin
            ways_c = 5'(MAX_WAYS);
        end
        else
        begin
            ways_c = {1'b0, ways_used};
        end

        hit_c      = |way_match;
        alloc_c    = !hit_c && !cur_reg.is_store && (5'(fill_rd_reg) < ways_c);
        replace_c  = !hit_c && !cur_reg.is_store && !(5'(fill_rd_reg) < ways_c);
        target     = hit_c ? hitway : victim;
        touch_rank = rank_rd_reg[target];

        tag_new  = tag_rd_reg;
        rank_new = rank_rd_reg;
        fill_new = fill_rd_reg;
        if (alloc_c)
        begin
            // New block goes into the next free way; every filled way ages.
            for (int i = 0; i < MAX_WAYS; i++)
            begin
                if (way_valid[i])
                begin
                    rank_new[i] = rank_rd_reg[i] + 1'b1;
                end
                else if (FILL_W'(i) == fill_rd_reg)
                begin
                    rank_new[i] = '0;
                    tag_new[i]  = cur_reg.blk;
                end
            end
            fill_new = fill_rd_reg + 1'b1;
        end
        else if (hit_c || replace_c)
        begin
            // Move the touched way to most recent; younger ways age by one.
            for (int i = 0; i < MAX_WAYS; i++)
            begin
                if (WAY_W'(i) == target)
                begin
                    rank_new[i] = '0;
                end
                else if (way_valid[i] && (rank_rd_reg[i] < touch_rank))
                begin
                    rank_new[i] = rank_rd_reg[i] + 1'b1;
                end
            end
            if (replace_c)
            begin
                tag_new[target] = cur_reg.blk;
            end
        end
    end

    // Fill count write port, shared with the clearing pass.
    always_comb
    begin
        if (clearing)
        begin
            fill_we    = (clr_cnt_reg < CLR_W'(MAX_SETS - 1)) ||
                         (clr_cnt_reg == CLR_W'(MAX_SETS - 1));
            fill_waddr = SET_W'(clr_cnt_reg);
            fill_wdata = '0;
        end
        else
        begin
            fill_we    = row_we;
            fill_waddr = cur_set;
            fill_wdata = fill_new;
        end
    end

    // Set row memories.
    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            tag_mem[cur_set]  <= tag_new;
            rank_mem[cur_set] <= rank_new;
        end
        if (fill_we)
        begin
            fill_mem[fill_waddr] <= fill_wdata;
        end
        if (row_re)
        begin
            tag_rd_reg  <= tag_mem[q_set];
            rank_rd_reg <= rank_mem[q_set];
            fill_rd_reg <= fill_mem[q_set];
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= salct_pkg::S_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
        end
    end

    // Transaction in flight and result registers.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= q_entry;
        end
        if (state_reg == salct_pkg::S_UPDATE)
        begin
            hit_reg       <= hit_c;
            load_data_reg <= cur_reg.is_store ? 64'd0 : mem_load_data;
        end
    end

    assign done      = done_reg;
    assign hit       = hit_reg;
    assign load_data = load_data_reg;

    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == salct_pkg::S_UPDATE))
        else $error("result strobe without a row update");

    a_update_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == salct_pkg::S_UPDATE) |=> (state_reg == salct_pkg::S_READ))
        else $error("row update took more than one cycle");

    a_pop_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> ((state_reg == salct_pkg::S_READ) && q_valid))
        else $error("transaction taken outside the read step");

    a_no_access_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !mem_ctl.acc_en)
        else $error("access issued during the clearing pass");

endmodule

// ===== src/set_assoc_lru_cache_tracker.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tracker: set-associative cache tracker, LRU, no write allocate
// Result: done is registered after the queue entry is taken, the set row is
// read (S_READ) and written back (S_UPDATE); done is high for exactly one cycle.
// Flow: the back end takes a new transaction only after the read and
// write-back of the previous one's tag and rank row. A two-entry queue
// lets start run ahead. Reset: a clearing pass zeroes the backing store
// and fill counts; busy stays high meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module set_assoc_lru_cache_tracker #(
    parameter int MAX_SETS   = 256,
    parameter int MAX_WAYS   = 8,
    parameter int MEM_BYTES  = 65536,
    parameter int MAX_ACCESS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               kind,
    input  logic [15:0]                        address,
    input  logic [3:0]                         access_size,
    input  logic [63:0]                        store_data,
    output logic                               done,
    output logic                               hit,
    output logic [63:0]                        load_data,
    input  logic                               cfg_we,
    input  logic [salct_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [salct_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int AW = $clog2(MEM_BYTES);

    logic [2:0]                  offset_bits_reg;
    logic [3:0]                  index_bits_reg;
    logic [3:0]                  ways_used_reg;

    logic                        q_valid;
    salct_pkg::item_t            q_entry;
    logic                        pop;
    logic                        clearing;
    salct_pkg::mem_ctl_t         mem_ctl;
    logic [AW-1:0]               acc_addr;
    logic [3:0]                  acc_size;
    logic [63:0]                 acc_data;
    logic [AW-4:0]               clr_word;
    logic [63:0]                 mem_load_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= 3'd3;
            index_bits_reg  <= 4'd8;
            ways_used_reg   <= 4'd8;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                salct_pkg::CFG_OFFSET_BITS: offset_bits_reg <= cfg_wdata[2:0];
                salct_pkg::CFG_INDEX_BITS:  index_bits_reg  <= cfg_wdata;
                salct_pkg::CFG_WAYS_USED:   ways_used_reg   <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    salct_front #(
        .MAX_ACCESS (MAX_ACCESS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .kind        (kind),
        .address     (address),
        .access_size (access_size),
        .store_data  (store_data),
        .offset_bits (offset_bits_reg),
        .index_bits  (index_bits_reg),
        .clearing    (clearing),
        .pop         (pop),
        .busy        (busy),
        .q_valid     (q_valid),
        .q_entry     (q_entry)
    );

    salct_back #(
        .MAX_SETS  (MAX_SETS),
        .MAX_WAYS  (MAX_WAYS),
        .MEM_BYTES (MEM_BYTES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .ways_used     (ways_used_reg),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .pop           (pop),
        .clearing      (clearing),
        .mem_ctl       (mem_ctl),
        .acc_addr      (acc_addr),
        .acc_size      (acc_size),
        .acc_data      (acc_data),
        .clr_word      (clr_word),
        .mem_load_data (mem_load_data),
        .done          (done),
        .hit           (hit),
        .load_data     (load_data)
    );

    salct_mem #(
        .MEM_BYTES (MEM_BYTES)
    ) u_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (mem_ctl),
        .acc_addr  (acc_addr),
        .acc_size  (acc_size),
        .acc_data  (acc_data),
        .clr_word  (clr_word),
        .load_data (mem_load_data)
    );

endmodule
